@@ src/mie_pkg.sv @@
// mie_pkg: shared types for the modular inverse core
// command codes from the controller and the status struct from the datapath
// no dependencies
`timescale 1ns / 1ps

package mie_pkg;

   // datapath commands, one per cycle
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_DIV,
      CMD_REDUCE,
      CMD_STEP,
      CMD_RESULT
   } cmd_type;

   // datapath status seen by the controller
   typedef struct packed {
      logic div_done;
      logic rc_zero;
   } dp_status_type;

endpackage

@@ src/mod_inverse_ext_euclid_core.sv @@
// modular inverse by the extended euclidean algorithm, one operand per beat
// divisions run on the shared serial divider, one quotient bit per cycle; one item at a time
// synchronous active-high reset: idle, no result pending, modulus back to 1
// depends on mie_pkg, mie_ctrl, mie_dp, mie_div
`timescale 1ns / 1ps

module mod_inverse_ext_euclid_core
   import mie_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [WIDTH-1:0] req_operand,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [WIDTH-1:0] rsp_inverse,
   output logic             rsp_has_inverse,
   output logic [WIDTH-1:0] rsp_gcd_value,
   input  logic             csr_wr_en,
   input  logic [WIDTH-1:0] csr_wr_data
);

   cmd_type          cmd;
   dp_status_type    status;
   logic [WIDTH-1:0] mod_value;

   // sequencer
   mie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // rows, divider and result register
   mie_dp #(.WIDTH(WIDTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_operand     (req_operand),
      .mod_value       (mod_value),
      .rsp_inverse     (rsp_inverse),
      .rsp_has_inverse (rsp_has_inverse),
      .rsp_gcd_value   (rsp_gcd_value)
   );

`ifndef SYNTH
   // an inverse is only flagged with a unit gcd
   a_flag_gcd : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_has_inverse || rsp_gcd_value == WIDTH'(1)))
      else $error("inverse flagged without unit gcd");

   // a flagged inverse lies below the modulus
   a_inv_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_inverse) |-> (rsp_inverse < mod_value))
      else $error("inverse not reduced");

   // a beat taken closes the input until the result is built
   a_one_item : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second beat taken while busy");

   // no inverse reported without one
   a_inv_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_inverse) |-> (rsp_inverse == '0))
      else $error("inverse nonzero without flag");
`endif

endmodule

@@ src/mie_div.sv @@
// mie_div: restoring serial divider, one quotient bit per cycle
// also accumulates quotient times a multiplicand as the quotient bits appear
// depends on nothing
`timescale 1ns / 1ps

module mie_div #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   input  logic [WIDTH-1:0] mult,
   output logic [WIDTH-1:0] remainder,
   output logic [WIDTH-1:0] product,
   output logic             done
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [WIDTH-1:0] mul_ff, mul_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             qbit;

   // one restoring step: shift in the next dividend bit and try the subtract
   always_comb begin
      trial = {rem_ff, dvd_ff[WIDTH-1]};
      diff  = trial - {1'b0, dsr_ff};
      qbit  = (trial >= {1'b0, dsr_ff});
   end

   // step sequencing
   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      mul_in  = mul_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         mul_in  = mult;
         rem_in  = '0;
         acc_in  = '0;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
         rem_in = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         // product stays within the modulus, so it never overflows WIDTH bits
         acc_in = {acc_ff[WIDTH-2:0], 1'b0} + (qbit ? mul_ff : '0);
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      mul_ff <= mul_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
   end

   assign remainder = rem_ff;
   assign product   = acc_ff;
   assign done      = done_ff;

endmodule

@@ src/mie_dp.sv @@
// mie_dp: datapath of the modular inverse core
// remainder rows, coefficient rows, modulus register and result register
// depends on mie_pkg and mie_div
`timescale 1ns / 1ps

module mie_dp
   import mie_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output dp_status_type    status,
   input  logic             csr_wr_en,
   input  logic [WIDTH-1:0] csr_wr_data,
   input  logic [WIDTH-1:0] req_operand,
   output logic [WIDTH-1:0] mod_value,
   output logic [WIDTH-1:0] rsp_inverse,
   output logic             rsp_has_inverse,
   output logic [WIDTH-1:0] rsp_gcd_value
);

   localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

   logic [WIDTH-1:0] mod_ff;
   logic [WIDTH-1:0] rp_ff, rp_in;
   logic [WIDTH-1:0] rc_ff, rc_in;
   logic [WIDTH-1:0] tp_ff, tp_in;
   logic [WIDTH-1:0] tc_ff, tc_in;
   logic             negc_ff, negc_in;
   logic [WIDTH-1:0] inv_ff, inv_in;
   logic             ok_ff, ok_in;
   logic [WIDTH-1:0] gcd_ff, gcd_in;
   logic [WIDTH-1:0] div_rem;
   logic [WIDTH-1:0] div_prod;
   logic             div_done;
   logic [WIDTH-1:0] mag;
   logic [WIDTH-1:0] inv_calc;
   logic             ok_calc;

   // shared serial divider: rp / rc, with q * tc alongside
   mie_div #(.WIDTH(WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd == CMD_DIV),
      .dividend  (rp_ff),
      .divisor   (rc_ff),
      .mult      (tc_ff),
      .remainder (div_rem),
      .product   (div_prod),
      .done      (div_done)
   );

   // modulus register
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= ONE;
      end else if (csr_wr_en) begin
         mod_ff <= csr_wr_data;
      end
   end

   // final coefficient folded into 0..modulus-1, coefficient never exceeds modulus
   always_comb begin
      ok_calc  = (mod_ff != '0) && (rp_ff == ONE);
      mag      = (tp_ff >= mod_ff) ? tp_ff - mod_ff : tp_ff;
      inv_calc = '0;
      if (ok_calc && mod_ff != ONE) begin
         if (!negc_ff && mag != '0) begin
            inv_calc = mod_ff - mag;
         end else begin
            inv_calc = mag;
         end
      end
   end

   // row updates
   always_comb begin
      rp_in   = rp_ff;
      rc_in   = rc_ff;
      tp_in   = tp_ff;
      tc_in   = tc_ff;
      negc_in = negc_ff;
      inv_in  = inv_ff;
      ok_in   = ok_ff;
      gcd_in  = gcd_ff;
      case (cmd)
         CMD_LOAD: begin
            // first division reduces the operand by the modulus
            rp_in   = req_operand;
            rc_in   = mod_ff;
            tp_in   = '0;
            tc_in   = ONE;
            negc_in = 1'b0;
         end
         CMD_REDUCE: begin
            rp_in = rc_ff;
            rc_in = div_rem;
         end
         CMD_STEP: begin
            rp_in   = rc_ff;
            rc_in   = div_rem;
            tp_in   = tc_ff;
            tc_in   = tp_ff + div_prod;
            negc_in = !negc_ff;
         end
         CMD_RESULT: begin
            inv_in = inv_calc;
            ok_in  = ok_calc;
            gcd_in = rp_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rp_ff   <= rp_in;
      rc_ff   <= rc_in;
      tp_ff   <= tp_in;
      tc_ff   <= tc_in;
      negc_ff <= negc_in;
      inv_ff  <= inv_in;
      ok_ff   <= ok_in;
      gcd_ff  <= gcd_in;
   end

   assign status.div_done = div_done;
   assign status.rc_zero  = (rc_ff == '0);
   assign mod_value       = mod_ff;
   assign rsp_inverse     = inv_ff;
   assign rsp_has_inverse = ok_ff;
   assign rsp_gcd_value   = gcd_ff;

endmodule

@@ src/mie_ctrl.sv @@
// mie_ctrl: sequencer of the modular inverse core
// steps the datapath through reduction, euclid steps and result hand-off
// depends on mie_pkg
`timescale 1ns / 1ps

module mie_ctrl
   import mie_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK_RED,
      ST_REDUCE,
      ST_CHECK,
      ST_STEP,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and command
   always_comb begin
      state_in     = state_ff;
      cmd          = CMD_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = ST_CHECK_RED;
            end
         end
         ST_CHECK_RED: begin
            // zero modulus skips straight to the result
            if (status.rc_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd      = CMD_DIV;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (status.div_done) begin
               cmd      = CMD_REDUCE;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.rc_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd      = CMD_DIV;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.div_done) begin
               cmd      = CMD_STEP;
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            // wait until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd          = CMD_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ tb/sv/mod_inverse_ext_euclid_core_test.sv @@
// self-checking bench for mod_inverse_ext_euclid_core: gcd, inverse flag and inverse
// directed and random operands over a range of moduli, with random bursts and stalls
// depends on mod_inverse_ext_euclid_core and its submodules
`timescale 1ns / 1ps

module mod_inverse_ext_euclid_core_test;

   localparam int W = 32;

   typedef struct packed {
      logic [W-1:0] inverse;
      logic         has_inverse;
      logic [W-1:0] gcd_value;
   } inv_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   logic [W-1:0] req_operand = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic [W-1:0] rsp_inverse;
   logic         rsp_has_inverse;
   logic [W-1:0] rsp_gcd_value;
   logic         csr_wr_en = 1'b0;
   logic [W-1:0] csr_wr_data = '0;

   logic [W-1:0]   operand_queue[$];
   inv_result_type inverse_expected[$];
   logic [W-1:0]   modulus_shadow = W'(1);
   logic           beat_taken = 1'b0;
   int             failures = 0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             stall_run = 0;
   logic           stall_hold = 1'b0;

   mod_inverse_ext_euclid_core #(.WIDTH(W)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operand     (req_operand),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_inverse     (rsp_inverse),
      .rsp_has_inverse (rsp_has_inverse),
      .rsp_gcd_value   (rsp_gcd_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #1 clock = ~clock;

   // extended euclid with the coefficient kept as magnitude and sign
   function automatic inv_result_type predict_inverse(logic [W-1:0] operand,
                                                      logic [W-1:0] modulus);
      logic [63:0]    r_prev, r_cur, r_next, t_prev, t_cur, t_next, quot, mag;
      logic           neg_cur;
      int             steps;
      inv_result_type res;
      res = '0;
      if (modulus == '0) begin
         res.gcd_value = operand;
         return res;
      end
      r_prev  = 64'(modulus);
      r_cur   = 64'(operand % modulus);
      t_prev  = '0;
      t_cur   = 64'd1;
      neg_cur = 1'b0;
      steps   = 0;
      while (steps < 2 * W + 4 && r_cur != '0) begin
         quot    = r_prev / r_cur;
         r_next  = r_prev - quot * r_cur;
         t_next  = t_prev + quot * t_cur;
         r_prev  = r_cur;
         r_cur   = r_next;
         t_prev  = t_cur;
         t_cur   = t_next;
         neg_cur = !neg_cur;
         steps++;
      end
      res.gcd_value = r_prev[W-1:0];
      if (r_prev == 64'd1) begin
         res.has_inverse = 1'b1;
         if (modulus != W'(1)) begin
            mag = t_prev % 64'(modulus);
            // the gcd coefficient carries the sign opposite to the current row
            if (neg_cur == 1'b0 && mag != '0)
               res.inverse = modulus - mag[W-1:0];
            else
               res.inverse = mag[W-1:0];
         end
      end
      return res;
   endfunction

   // request driver: bursts of beats with random gaps, changes on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         beat_taken = 1'b0;
      end else if (!req_valid || beat_taken) begin
         beat_taken = 1'b0;
         if (gap_left > 0 || operand_queue.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_valid   <= 1'b1;
            req_operand <= operand_queue.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 6);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // response stall pattern: alternating stall and free runs, some of them long
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_run == 0) begin
            stall_hold = !stall_hold;
            if (stall_hold)
               stall_run = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 4);
            else
               stall_run = $urandom_range(1, 80);
         end
         stall_run--;
         rsp_stall <= stall_hold;
      end
   end

   // monitor: check result beats against the oldest prediction, predict accepted beats
   always @(posedge clock) begin
      inv_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (inverse_expected.size() == 0) begin
               $error("unexpected result beat: inverse %0h gcd %0h",
                      rsp_inverse, rsp_gcd_value);
               failures++;
            end else begin
               want = inverse_expected.pop_front();
               if (rsp_inverse !== want.inverse) begin
                  $error("inverse: expected %0h, got %0h", want.inverse, rsp_inverse);
                  failures++;
               end
               if (rsp_has_inverse !== want.has_inverse) begin
                  $error("has_inverse: expected %0h, got %0h",
                         want.has_inverse, rsp_has_inverse);
                  failures++;
               end
               if (rsp_gcd_value !== want.gcd_value) begin
                  $error("gcd_value: expected %0h, got %0h", want.gcd_value, rsp_gcd_value);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            inverse_expected = {inverse_expected,
                                predict_inverse(req_operand, modulus_shadow)};
            beat_taken = 1'b1;
         end
      end
   end

   task automatic send(logic [W-1:0] operand);
      operand_queue = {operand_queue, operand};
   endtask

   // wait until every queued beat has gone in and its result come back
   task automatic wait_idle();
      while (operand_queue.size() != 0 || req_valid || inverse_expected.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write while idle; items follow only after the write edge
   task automatic set_modulus(logic [W-1:0] value);
      @(negedge clock);
      csr_wr_en      <= 1'b1;
      csr_wr_data    <= value;
      modulus_shadow = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [W-1:0] pick_modulus(int kind);
      logic [W-1:0] m;
      case (kind)
         0: m = $urandom_range(1, 16);
         1: m = $urandom_range(17, 65535);
         2: m = $urandom | 32'h8000_0000;
         3: m = 32'h1 << $urandom_range(1, 31);
         4: begin
            m = $urandom;
            if (m == '0)
               m = W'(1);
         end
         default: begin
            case ($urandom_range(0, 2))
               0: m = 32'hFFFF_FFFF;
               1: m = 32'd4294967291;
               default: m = 32'd2971215073;
            endcase
         end
      endcase
      return m;
   endfunction

   function automatic logic [W-1:0] pick_operand(logic [W-1:0] m);
      logic [W-1:0] a;
      case ($urandom_range(0, 9))
         0: a = '0;
         1: begin
            case ($urandom_range(0, 2))
               0: a = '1;
               1: a = m - W'(1);
               default: a = m;
            endcase
         end
         2, 3: a = $urandom % m;
         4: a = $urandom & ~32'h1;
         5: a = $urandom_range(1, 255);
         default: a = $urandom;
      endcase
      return a;
   endfunction

   // stimulus
   initial begin
      logic [W-1:0] m;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // modulus left at its reset value of one
      send(0);
      send(5);
      send('1);
      wait_idle();

      // all-ones modulus, composite; operand equal to it reduces to zero
      set_modulus('1);
      send(0);
      send(1);
      send(2);
      send(32'hFFFF_FFFE);
      send('1);
      send(3);
      send(32'h8000_0000);
      wait_idle();

      // largest prime below two to the 32
      set_modulus(32'd4294967291);
      send(1);
      send(32'd4294967290);
      send('1);
      send(32'hAAAA_AAAA);
      send(32'h5555_5555);
      wait_idle();

      // consecutive fibonacci numbers give the longest euclid chain
      set_modulus(32'd2971215073);
      send(32'd1836311903);
      wait_idle();

      set_modulus(2);
      send(0);
      send(1);
      send(3);
      wait_idle();

      set_modulus(12);
      send(5);
      send(6);
      send(24);
      wait_idle();

      // random operands over a spread of moduli
      for (int phase = 0; phase < 12; phase++) begin
         m = pick_modulus(phase % 6);
         set_modulus(m);
         for (int n = 0; n < 31; n++)
            send(pick_operand(m));
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog
   initial begin
      #8_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
